// ===== rtl/yuvrgb_pkg.sv =====
// Shared types and constants for the YUV 4:2:2 pixel pair to RGB888 converter.
// Holds the pixel format codes and the packed input / result word layouts.
// No dependencies.
package yuvrgb_pkg;

    typedef enum logic [2:0] {
        FMT_NV12 = 3'd0,
        FMT_NV21 = 3'd1,
        FMT_NV16 = 3'd2,
        FMT_NV61 = 3'd3,
        FMT_UYVY = 3'd4,
        FMT_YUYV = 3'd5
    } pixel_format_t;

    localparam logic [2:0] PIXEL_FORMAT_RESET = 3'd0;

    // Input word: four raw bytes in memory order plus the second-pixel flag.
    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [7:0] fourth_byte;
        logic       second_valid;
    } in_word_t;

    // Result word: two RGB888 pixels plus the second-pixel flag.
    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       second_present;
    } out_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Byte roles picked out of one input word.
    typedef struct packed {
        logic [7:0] y0;
        logic [7:0] y1;
        logic [7:0] u;
        logic [7:0] v;
        logic       fmt_ok;
    } yuv_pair_t;

endpackage

// ===== rtl/yuvrgb_unpack.sv =====
// Byte role selection for the YUV to RGB converter.
// Maps four raw bytes to Y0, Y1, U, V under the configured format.
// Depends on yuvrgb_pkg.
module yuvrgb_unpack (
    input  logic [2:0]           pixel_format,
    input  yuvrgb_pkg::in_word_t in_word,
    output yuvrgb_pkg::yuv_pair_t pair
);

    always_comb begin
        pair.y0     = in_word.first_byte;
        pair.y1     = in_word.second_byte;
        pair.u      = in_word.third_byte;
        pair.v      = in_word.fourth_byte;
        pair.fmt_ok = 1'b1;
        unique case (pixel_format)
            yuvrgb_pkg::FMT_NV12, yuvrgb_pkg::FMT_NV16: begin
                pair.u = in_word.third_byte;
                pair.v = in_word.fourth_byte;
            end
            yuvrgb_pkg::FMT_NV21, yuvrgb_pkg::FMT_NV61: begin
                pair.v = in_word.third_byte;
                pair.u = in_word.fourth_byte;
            end
            yuvrgb_pkg::FMT_UYVY: begin
                pair.u  = in_word.first_byte;
                pair.y0 = in_word.second_byte;
                pair.v  = in_word.third_byte;
                pair.y1 = in_word.fourth_byte;
            end
            yuvrgb_pkg::FMT_YUYV: begin
                pair.y0 = in_word.first_byte;
                pair.u  = in_word.second_byte;
                pair.y1 = in_word.third_byte;
                pair.v  = in_word.fourth_byte;
            end
            default: begin
                // unused codes: drop the word
                pair.fmt_ok = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/yuvrgb_lane.sv =====
// One conversion lane: full-range BT.601 YUV to RGB888 for a single pixel.
// Registered chroma products, then sum, floor shift and clamp (combinational out).
// Depends on yuvrgb_pkg.
module yuvrgb_lane (
    input  logic              aclk,
    input  logic              adv,
    input  logic [7:0]        y,
    input  logic [7:0]        u,
    input  logic [7:0]        v,
    output yuvrgb_pkg::rgb_t  pix
);

    logic signed [8:0]  d;
    logic signed [8:0]  e;
    logic signed [16:0] cr_next;
    logic signed [16:0] cg_next;
    logic signed [16:0] cb_next;
    logic signed [16:0] cr_reg;
    logic signed [16:0] cg_reg;
    logic signed [16:0] cb_reg;
    logic [7:0]         y_reg;
    logic signed [18:0] luma;
    logic signed [18:0] sum_r;
    logic signed [18:0] sum_g;
    logic signed [18:0] sum_b;

    function automatic logic [7:0] clamp8(input logic signed [18:0] s);
        logic [7:0] res;
        if (s[18]) begin
            res = 8'd0;
        end else if (|s[17:16]) begin
            res = 8'd255;
        end else begin
            res = s[15:8];
        end
        return res;
    endfunction

    assign d = $signed({1'b0, u}) - 9'sd128;
    assign e = $signed({1'b0, v}) - 9'sd128;

    assign cr_next = 17'(e) * 17'sd359;
    assign cg_next = 17'(d) * 17'sd88 + 17'(e) * 17'sd183;
    assign cb_next = 17'(d) * 17'sd454;

    always_ff @(posedge aclk) begin
        if (adv) begin
            cr_reg <= cr_next;
            cg_reg <= cg_next;
            cb_reg <= cb_next;
            y_reg  <= y;
        end
    end

    // 256*Y plus rounding bias, then floor shift via bit select in clamp8
    assign luma  = $signed({3'b000, y_reg, 8'h80});
    assign sum_r = luma + 19'(cr_reg);
    assign sum_g = luma - 19'(cg_reg);
    assign sum_b = luma + 19'(cb_reg);

    assign pix.red   = clamp8(sum_r);
    assign pix.green = clamp8(sum_g);
    assign pix.blue  = clamp8(sum_b);

endmodule

// ===== rtl/yuv422_pair_to_rgb888_unit.sv =====
// Top level of the YUV 4:2:2 pixel pair to RGB888 converter.
// Instantiates yuvrgb_unpack and two yuvrgb_lane copies; uses yuvrgb_pkg.
//
// Accepts one pixel pair word per clock unless the output stalls, and returns one
// RGB888 pair word per accepted word. A word passes the registered chroma products
// inside each lane, then the merge register that drives m_data. Both lanes run
// in parallel on the shared U/V pair, and the pipeline advances whenever the
// merge register is empty or being taken, so s_ready follows m_ready in the same
// cycle. Words that arrive while pixel_format holds an unused code (6 or 7) are
// taken and dropped. When second_valid is low the second pixel comes out as
// zero. Write pixel_format only while idle.
module yuv422_pair_to_rgb888_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  yuvrgb_pkg::in_word_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output yuvrgb_pkg::out_word_t m_data
);

    logic [2:0]             pixel_format_reg;
    yuvrgb_pkg::yuv_pair_t  pair;
    yuvrgb_pkg::rgb_t       pix_first;
    yuvrgb_pkg::rgb_t       pix_second;
    yuvrgb_pkg::out_word_t  m_data_next;
    yuvrgb_pkg::out_word_t  m_data_reg;
    logic                   adv;
    logic                   v1_reg;
    logic                   second_reg;
    logic                   m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg <= yuvrgb_pkg::PIXEL_FORMAT_RESET;
        end else if (cfg_wr_en) begin
            pixel_format_reg <= cfg_wr_data;
        end
    end

    yuvrgb_unpack u_unpack (
        .pixel_format (pixel_format_reg),
        .in_word      (s_data),
        .pair         (pair)
    );

    yuvrgb_lane u_lane_first (
        .aclk (aclk),
        .adv  (adv),
        .y    (pair.y0),
        .u    (pair.u),
        .v    (pair.v),
        .pix  (pix_first)
    );

    yuvrgb_lane u_lane_second (
        .aclk (aclk),
        .adv  (adv),
        .y    (pair.y1),
        .u    (pair.u),
        .v    (pair.v),
        .pix  (pix_second)
    );

    // merge both lanes into the result word; blank the second pixel when absent
    always_comb begin
        m_data_next.red_first      = pix_first.red;
        m_data_next.green_first    = pix_first.green;
        m_data_next.blue_first     = pix_first.blue;
        m_data_next.red_second     = second_reg ? pix_second.red   : 8'd0;
        m_data_next.green_second   = second_reg ? pix_second.green : 8'd0;
        m_data_next.blue_second    = second_reg ? pix_second.blue  : 8'd0;
        m_data_next.second_present = second_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= s_valid && pair.fmt_ok;
            m_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            second_reg <= s_data.second_valid;
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ===== rtl/yuvrgb_checker.sv =====
// Port-level checker for yuv422_pair_to_rgb888_unit, bound to the top level.
// Watches the result channel and the ready path; uses yuvrgb_pkg.
module yuvrgb_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input yuvrgb_pkg::out_word_t m_data
);

    // hold a stalled result word
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // absent second pixel must read as black
    a_second_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.second_present |->
            m_data.red_second == 8'd0 && m_data.green_second == 8'd0 &&
            m_data.blue_second == 8'd0)
        else $error("second pixel not blanked");

    // an empty output stage must never stall the input
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // drop any result during reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind yuv422_pair_to_rgb888_unit yuvrgb_checker u_yuvrgb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== verif/rgb_pair_checker.sv =====
`timescale 1ns / 100ps
// Result checker for yuv422_pair_to_rgb888_unit: follows pixel_format on the config port,
// predicts the RGB888 pair for each accepted input word and compares result words in order.
// Depends on yuvrgb_pkg.
module rgb_pair_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_wr_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  yuvrgb_pkg::in_word_t  s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  yuvrgb_pkg::out_word_t m_data,
    output int                    mismatches,
    output int                    pending
);
    import yuvrgb_pkg::*;

    logic [2:0] fmt_reg = PIXEL_FORMAT_RESET;
    out_word_t  rgb_pairs_due[$];
    int         fail_count = 0;
    int         due_count = 0;

    assign mismatches = fail_count;
    assign pending    = due_count;

    function automatic logic [7:0] clamp_channel8(input int value);
        if (value < 0) return 8'd0;
        if (value > 255) return 8'd255;
        return value[7:0];
    endfunction

    function automatic rgb_t yuv_to_rgb(input logic [7:0] y, input logic [7:0] u,
                                        input logic [7:0] v);
        int   luma;
        int   d;
        int   e;
        rgb_t px;
        luma = 256 * int'(y);
        d    = int'(u) - 128;
        e    = int'(v) - 128;
        // arithmetic shift floors negative sums, as the block does
        px.red   = clamp_channel8((luma + 359 * e + 128) >>> 8);
        px.green = clamp_channel8((luma - 88 * d - 183 * e + 128) >>> 8);
        px.blue  = clamp_channel8((luma + 454 * d + 128) >>> 8);
        return px;
    endfunction

    // Returns 0 when the format code is unused and the word is dropped.
    function automatic bit predict_pair(input logic [2:0] fmt, input in_word_t w,
                                        output out_word_t r);
        logic [7:0] y0;
        logic [7:0] y1;
        logic [7:0] u;
        logic [7:0] v;
        rgb_t       p0;
        rgb_t       p1;
        r = '0;
        case (fmt)
            FMT_NV12, FMT_NV16: begin
                y0 = w.first_byte; y1 = w.second_byte; u = w.third_byte; v = w.fourth_byte;
            end
            FMT_NV21, FMT_NV61: begin
                y0 = w.first_byte; y1 = w.second_byte; v = w.third_byte; u = w.fourth_byte;
            end
            FMT_UYVY: begin
                u = w.first_byte; y0 = w.second_byte; v = w.third_byte; y1 = w.fourth_byte;
            end
            FMT_YUYV: begin
                y0 = w.first_byte; u = w.second_byte; y1 = w.third_byte; v = w.fourth_byte;
            end
            default: return 1'b0;
        endcase
        p0 = yuv_to_rgb(y0, u, v);
        p1 = w.second_valid ? yuv_to_rgb(y1, u, v) : '0;
        r  = {p0.red, p0.green, p0.blue, p1.red, p1.green, p1.blue, w.second_valid};
        return 1'b1;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        out_word_t want;
        out_word_t fresh;
        bit        known;
        if (!aresetn) begin
            fmt_reg = PIXEL_FORMAT_RESET;
            rgb_pairs_due.delete();
        end else begin
            // retire before pushing: a result can never belong to this edge's word
            if (m_valid && m_ready) begin
                if (rgb_pairs_due.size() == 0) begin
                    $display("%0t: result word %h with nothing expected", $time, m_data);
                    fail_count++;
                end else begin
                    want = rgb_pairs_due.pop_front();
                    check_field("red_first", want.red_first, m_data.red_first);
                    check_field("green_first", want.green_first, m_data.green_first);
                    check_field("blue_first", want.blue_first, m_data.blue_first);
                    check_field("red_second", want.red_second, m_data.red_second);
                    check_field("green_second", want.green_second, m_data.green_second);
                    check_field("blue_second", want.blue_second, m_data.blue_second);
                    check_field("second_present", 8'(want.second_present),
                                8'(m_data.second_present));
                end
            end
            if (s_valid && s_ready) begin
                known = predict_pair(fmt_reg, s_data, fresh);
                if (known) rgb_pairs_due.push_back(fresh);
            end
            if (cfg_wr_en) fmt_reg = cfg_wr_data;
        end
        due_count <= rgb_pairs_due.size();
    end

endmodule

// ===== verif/yuv422_pair_to_rgb888_unit_tb.sv =====
`timescale 1ns / 100ps
// Top testbench for yuv422_pair_to_rgb888_unit: drives pixel pair words and format writes,
// stalls the result side at random and gives the verdict. Depends on yuvrgb_pkg and
// rgb_pair_checker.
module yuv422_pair_to_rgb888_unit_tb;
    import yuvrgb_pkg::*;

    localparam logic [2:0] FMT_SPARE_LOW  = 3'd6;
    localparam logic [2:0] FMT_SPARE_HIGH = 3'd7;
    localparam int         RANDOM_ITEMS   = 850;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         WATCHDOG_LIMIT = 400;

    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [2:0] cfg_wr_data = 3'd0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    in_word_t   s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    out_word_t  m_data;

    int         mismatches;
    int         pending;
    bit         no_idle     = 1'b0;
    int         ready_hold  = 1;
    int         quiet_cycles = 0;

    yuv422_pair_to_rgb888_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    rgb_pair_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Result side: after each taken word, drop ready for a drawn number of cycles.
    always @(posedge aclk) begin : result_sink
        int stall;
        stall = no_idle ? 0 : $urandom_range(0, 9);
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 1;
        end else if (m_ready) begin
            if (m_valid) begin
                m_ready    <= (stall == 0);
                ready_hold <= stall;
            end
        end else if (ready_hold <= 1) begin
            m_ready <= 1'b1;
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("yuv422_pair_to_rgb888_unit_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Hold the word until taken; a gap of zero keeps valid high into the next word.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Write the format only once the pipe has emptied, dropped words included.
    task automatic write_format(input logic [2:0] code);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= code;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        int         n;
        int         random_sent;
        logic [2:0] code;
        random_sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset format (NV12): neutral chroma, clamping at both ends, absent second pixel
        send_word({8'd0, 8'd0, 8'd128, 8'd128, 1'b1});
        send_word({8'd255, 8'd255, 8'd128, 8'd128, 1'b1});
        send_word({8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
        send_word({8'd0, 8'd0, 8'd0, 8'd0, 1'b1});
        send_word({8'd0, 8'd255, 8'd255, 8'd0, 1'b1});
        send_word({8'd200, 8'd77, 8'd60, 8'd220, 1'b0});

        for (int f = FMT_NV21; f <= FMT_YUYV; f++) begin
            write_format(3'(f));
            send_word({8'd255, 8'd0, 8'd255, 8'd0, 1'b1});
            send_word({8'd0, 8'd255, 8'd0, 8'd255, 1'b0});
        end

        // spare codes: words are taken and dropped
        write_format(FMT_SPARE_LOW);
        send_word({8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
        send_word({8'd1, 8'd2, 8'd3, 8'd4, 1'b0});
        write_format(FMT_SPARE_HIGH);
        send_word({8'd0, 8'd0, 8'd0, 8'd0, 1'b1});

        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 15))
                0: code = FMT_SPARE_LOW;
                1: code = FMT_SPARE_HIGH;
                default: code = 3'($urandom_range(FMT_NV12, FMT_YUYV));
            endcase
            write_format(code);
            no_idle = ($urandom_range(0, 3) == 0);
            n = (code > FMT_YUYV) ? $urandom_range(2, 8) : $urandom_range(20, 80);
            for (int i = 0; i < n; i++) begin
                send_word({pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                           1'($urandom_range(0, 3) != 0)});
                if (code <= FMT_YUYV) random_sent++;
            end
        end

        s_valid <= 1'b0;
        no_idle = 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("yuv422_pair_to_rgb888_unit_tb: clean");
        end else begin
            $display("yuv422_pair_to_rgb888_unit_tb: errors");
        end
        $finish;
    end

endmodule
